/* sv/box_blur_window_filter_macros.svh */
// Assertion macros shared by the box blur window filter RTL.
`ifndef BOX_BLUR_WINDOW_FILTER_MACROS_SVH
`define BOX_BLUR_WINDOW_FILTER_MACROS_SVH

// Condition holds at every clock edge outside reset.
`define BBW_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define BBW_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define BBW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/bbw_pkg.sv */
// Constants and types of the box blur window filter.
package bbw_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int WINDOW     = 12;
    localparam int NCH        = 3;
    localparam int PIX_W      = 8;
    localparam int COLSUM_W   = 12;
    localparam int WIN_W      = 16;
    localparam int WIDTH_W    = 11;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int SLOT_W     = $clog2(WINDOW);
    localparam int ROWS_W     = $clog2(WINDOW + 1);
    localparam int LINE_AW    = SLOT_W + COL_W;
    localparam int LINE_DEPTH = WINDOW * MAX_WIDTH;
    localparam int AREA       = WINDOW * WINDOW;

    // Divide by AREA as a multiply by a rounded-up reciprocal; exact for WIN_W-bit sums
    // because the reciprocal error times 2**WIN_W stays under 2**DIV_SHIFT.
    localparam int DIV_SHIFT  = WIN_W + 8;
    localparam int DIV_RECIP  = ((1 << DIV_SHIFT) + AREA - 1) / AREA;
    localparam int RECIP_W    = $clog2(DIV_RECIP + 1);
    localparam int PROD_W     = WIN_W + RECIP_W;

    typedef logic [NCH-1:0][PIX_W-1:0]    pix_vec_t;
    typedef logic [NCH-1:0][COLSUM_W-1:0] cs_vec_t;
    typedef logic [NCH-1:0][WIN_W-1:0]    win_vec_t;

    // Stage 1: pixel waiting for its line store and column sum reads.
    typedef struct packed {
        pix_vec_t          pix;
        logic [COL_W-1:0]  col;
        logic [SLOT_W-1:0] slot;
        logic [SLOT_W-1:0] ridx;
        logic              first_row;
        logic              full;
        logic              col_zero;
        logic              col_ge_win;
    } s1_t;

    // Stage 2: finished column sums for the horizontal window update.
    typedef struct packed {
        cs_vec_t           cs;
        logic [SLOT_W-1:0] ridx;
        logic              col_zero;
        logic              col_ge_win;
    } s2_t;

endpackage

/* sv/box_blur_window_filter.sv */
// Box blur window filter top level: streaming 12 by 12 box mean over RGB pixels.
//
// Usage:
//   Pixels enter in raster order on the pixel channel (pixel_valid/pixel_ready);
//   frame_start marks the first pixel of a frame. Each pixel yields one result on
//   the mean channel (mean_valid/mean_ready): per color, the sum over the 12 by 12
//   window whose bottom right corner is that pixel, divided by 144 and truncated.
//   Positions above or left of the frame count as zero.
//   The cfg channel writes row_width (pixels per row); it is always ready. The user
//   must write it only while no pixel is in flight; the block does not enforce this.
//   Zero acts as 1, values above 1024 act as 1024.
// Timing:
//   One pixel per clock while the receiver keeps taking results. A result shows on
//   the mean port after the registers for the line store and column sum RAM reads,
//   the column sum update, the window update and the divide, in that order.
// Reset:
//   Clears the pipeline and the row and column counters; row_width returns to 1024.
//   The RAMs are not cleared; an entry is read only after this frame wrote it.
// Stall:
//   A stalled receiver holds the output register; the four-deep pipeline keeps
//   accepting until every stage is full, then pixel_ready drops.
`include "box_blur_window_filter_macros.svh"

module box_blur_window_filter (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [bbw_pkg::WIDTH_W-1:0]   row_width,
    input  logic                          pixel_valid,
    output logic                          pixel_ready,
    input  logic [bbw_pkg::PIX_W-1:0]     pixel_red,
    input  logic [bbw_pkg::PIX_W-1:0]     pixel_green,
    input  logic [bbw_pkg::PIX_W-1:0]     pixel_blue,
    input  logic                          frame_start,
    output logic                          mean_valid,
    input  logic                          mean_ready,
    output logic [bbw_pkg::PIX_W-1:0]     mean_red,
    output logic [bbw_pkg::PIX_W-1:0]     mean_green,
    output logic [bbw_pkg::PIX_W-1:0]     mean_blue
);

    // Configuration and frame position state.
    logic [bbw_pkg::WIDTH_W-1:0] row_width_reg;
    logic [bbw_pkg::COL_W-1:0]   col_reg,  col_next;
    logic [bbw_pkg::SLOT_W-1:0]  slot_reg, slot_next;
    logic [bbw_pkg::ROWS_W-1:0]  rows_reg, rows_next;
    logic [bbw_pkg::SLOT_W-1:0]  ridx_reg, ridx_next;

    // Pipeline valids and payloads.
    logic               s1_v_reg, s2_v_reg, s3_v_reg, out_v_reg;
    bbw_pkg::s1_t       s1_reg,   s1_next;
    bbw_pkg::s2_t       s2_reg,   s2_next;
    bbw_pkg::win_vec_t  s3_reg;
    bbw_pkg::pix_vec_t  mean_reg, mean_next;

    // Column sum bypass for a back-to-back visit of the same column (narrow rows).
    logic               fwd_v_reg, fwd_v_next;
    bbw_pkg::cs_vec_t   fwd_cs_reg;

    // Horizontal running sum: ring of the last WINDOW column sums plus the total.
    bbw_pkg::cs_vec_t   ring_reg [bbw_pkg::WINDOW];
    bbw_pkg::win_vec_t  win_reg,  win_next;

    logic [bbw_pkg::WIDTH_W-1:0] width_act;
    logic                        accept;
    logic                        en1, en2, en3, en_out;
    logic                        s1_wr, s2_upd;
    logic [bbw_pkg::LINE_AW-1:0] line_rd_addr, line_wr_addr;
    logic [bbw_pkg::NCH*bbw_pkg::PIX_W-1:0]    line_rd_data, line_wr_data;
    logic [bbw_pkg::NCH*bbw_pkg::COLSUM_W-1:0] cs_rd_data;
    bbw_pkg::cs_vec_t            cs_rd, s1_cs;
    bbw_pkg::pix_vec_t           pix_in;

    // Handshake: each stage loads when it is empty or its content moves on.
    assign en_out      = !out_v_reg || mean_ready;
    assign en3         = !s3_v_reg  || en_out;
    assign en2         = !s2_v_reg  || en3;
    assign en1         = !s1_v_reg  || en2;
    assign pixel_ready = en1;
    assign accept      = pixel_valid && en1;
    assign s1_wr       = s1_v_reg && en2;
    assign s2_upd      = s2_v_reg && en3;
    assign cfg_ready   = 1'b1;

    assign pix_in = {pixel_blue, pixel_green, pixel_red};

    // Clamp the programmed width into the legal range.
    always_comb
    begin
        if (row_width_reg == '0)
        begin
            width_act = bbw_pkg::WIDTH_W'(1);
        end
        else if (row_width_reg > bbw_pkg::WIDTH_W'(bbw_pkg::MAX_WIDTH))
        begin
            width_act = bbw_pkg::WIDTH_W'(bbw_pkg::MAX_WIDTH);
        end
        else
        begin
            width_act = row_width_reg;
        end
    end

    // Position of the incoming pixel and the counters after it.
    always_comb
    begin
        logic [bbw_pkg::COL_W-1:0]   c;
        logic [bbw_pkg::SLOT_W-1:0]  s;
        logic [bbw_pkg::ROWS_W-1:0]  r;
        logic [bbw_pkg::SLOT_W-1:0]  ri;
        logic [bbw_pkg::WIDTH_W-1:0] c1;

        c  = col_reg;
        s  = slot_reg;
        r  = rows_reg;
        ri = ridx_reg;
        if (frame_start)
        begin
            c  = '0;
            s  = '0;
            r  = '0;
            ri = '0;
        end
        // Width shrunk under a running row: start a new row.
        if (bbw_pkg::WIDTH_W'(c) >= width_act)
        begin
            c  = '0;
            s  = (int'(s) == bbw_pkg::WINDOW - 1) ? '0 : s + 1'b1;
            r  = (int'(r) < bbw_pkg::WINDOW) ? r + 1'b1 : r;
            ri = '0;
        end

        s1_next.pix        = pix_in;
        s1_next.col        = c;
        s1_next.slot       = s;
        s1_next.ridx       = ri;
        s1_next.first_row  = (r == '0);
        s1_next.full       = (int'(r) >= bbw_pkg::WINDOW);
        s1_next.col_zero   = (c == '0);
        s1_next.col_ge_win = (int'(c) >= bbw_pkg::WINDOW);

        line_rd_addr = {s, c};

        // Hit the bypass when the pixel leaving stage 1 now wrote this column.
        fwd_v_next = s1_v_reg && (s1_reg.col == c);

        c1 = bbw_pkg::WIDTH_W'(c) + 1'b1;
        if (c1 >= width_act)
        begin
            col_next  = '0;
            slot_next = (int'(s) == bbw_pkg::WINDOW - 1) ? '0 : s + 1'b1;
            rows_next = (int'(r) < bbw_pkg::WINDOW) ? r + 1'b1 : r;
            ridx_next = '0;
        end
        else
        begin
            col_next  = c1[bbw_pkg::COL_W-1:0];
            slot_next = s;
            rows_next = r;
            ridx_next = (int'(ri) == bbw_pkg::WINDOW - 1) ? '0 : ri + 1'b1;
        end
    end

    // Line store: the last WINDOW rows of pixels, one row per slot.
    bbw_ram #(
        .WIDTH (bbw_pkg::NCH * bbw_pkg::PIX_W),
        .DEPTH (bbw_pkg::LINE_DEPTH)
    ) u_line_ram (
        .clk     (clk),
        .wr_en   (s1_wr),
        .wr_addr (line_wr_addr),
        .wr_data (line_wr_data),
        .rd_en   (en1),
        .rd_addr (line_rd_addr),
        .rd_data (line_rd_data)
    );

    // Column sums: vertical sum of the last WINDOW rows per column.
    bbw_ram #(
        .WIDTH (bbw_pkg::NCH * bbw_pkg::COLSUM_W),
        .DEPTH (bbw_pkg::MAX_WIDTH)
    ) u_colsum_ram (
        .clk     (clk),
        .wr_en   (s1_wr),
        .wr_addr (s1_reg.col),
        .wr_data (s1_cs),
        .rd_en   (en1),
        .rd_addr (s1_next.col),
        .rd_data (cs_rd_data)
    );

    assign cs_rd        = cs_rd_data;
    assign line_wr_addr = {s1_reg.slot, s1_reg.col};
    assign line_wr_data = {s1_reg.pix[0], s1_reg.pix[1], s1_reg.pix[2]};

    // Stage 1: add the new pixel, drop the one leaving the window from the top.
    always_comb
    begin
        logic [bbw_pkg::COLSUM_W-1:0] base;
        logic [bbw_pkg::PIX_W-1:0]    old;

        for (int ch = 0; ch < bbw_pkg::NCH; ch++)
        begin
            base = fwd_v_reg ? fwd_cs_reg[ch] : cs_rd[ch];
            old  = line_rd_data[(bbw_pkg::NCH - 1 - ch) * bbw_pkg::PIX_W +: bbw_pkg::PIX_W];
            if (s1_reg.first_row)
            begin
                s1_cs[ch] = bbw_pkg::COLSUM_W'(s1_reg.pix[ch]);
            end
            else
            begin
                s1_cs[ch] = base + bbw_pkg::COLSUM_W'(s1_reg.pix[ch])
                          - (s1_reg.full ? bbw_pkg::COLSUM_W'(old) : '0);
            end
        end
        s2_next.cs         = s1_cs;
        s2_next.ridx       = s1_reg.ridx;
        s2_next.col_zero   = s1_reg.col_zero;
        s2_next.col_ge_win = s1_reg.col_ge_win;
    end

    // Stage 2: slide the horizontal window by one column.
    always_comb
    begin
        for (int ch = 0; ch < bbw_pkg::NCH; ch++)
        begin
            win_next[ch] = (s2_reg.col_zero ? '0 : win_reg[ch])
                         + bbw_pkg::WIN_W'(s2_reg.cs[ch])
                         - (s2_reg.col_ge_win ? bbw_pkg::WIN_W'(ring_reg[s2_reg.ridx][ch]) : '0);
        end
    end

    // Stage 3: divide by the window area through the reciprocal multiply.
    always_comb
    begin
        logic [bbw_pkg::PROD_W-1:0] prod;

        for (int ch = 0; ch < bbw_pkg::NCH; ch++)
        begin
            prod = bbw_pkg::PROD_W'(s3_reg[ch])
                 * bbw_pkg::PROD_W'(bbw_pkg::DIV_RECIP);
            mean_next[ch] = prod[bbw_pkg::DIV_SHIFT +: bbw_pkg::PIX_W];
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_width_reg <= bbw_pkg::WIDTH_W'(bbw_pkg::MAX_WIDTH);
            col_reg       <= '0;
            slot_reg      <= '0;
            rows_reg      <= '0;
            ridx_reg      <= '0;
            s1_v_reg      <= 1'b0;
            s2_v_reg      <= 1'b0;
            s3_v_reg      <= 1'b0;
            out_v_reg     <= 1'b0;
            fwd_v_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                row_width_reg <= row_width;
            end
            if (accept)
            begin
                col_reg  <= col_next;
                slot_reg <= slot_next;
                rows_reg <= rows_next;
                ridx_reg <= ridx_next;
            end
            if (en1)
            begin
                s1_v_reg  <= pixel_valid;
                fwd_v_reg <= fwd_v_next;
            end
            if (en2)
            begin
                s2_v_reg <= s1_v_reg;
            end
            if (en3)
            begin
                s3_v_reg <= s2_v_reg;
            end
            if (en_out)
            begin
                out_v_reg <= s3_v_reg;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_reg     <= s1_next;
            fwd_cs_reg <= s1_cs;
        end
        if (en2)
        begin
            s2_reg <= s2_next;
        end
        if (s2_upd)
        begin
            win_reg                <= win_next;
            ring_reg[s2_reg.ridx]  <= s2_reg.cs;
        end
        if (en3)
        begin
            s3_reg <= win_next;
        end
        if (en_out)
        begin
            mean_reg <= mean_next;
        end
    end

    assign mean_valid = out_v_reg;
    assign mean_red   = mean_reg[0];
    assign mean_green = mean_reg[1];
    assign mean_blue  = mean_reg[2];

    `BBW_ASSERT_ALWAYS(a_rows_sat, int'(rows_reg) <= bbw_pkg::WINDOW, "rows count past window")
    `BBW_ASSERT_ALWAYS(a_slot_range, int'(slot_reg) < bbw_pkg::WINDOW, "line slot out of range")
    `BBW_ASSERT_NEXT(a_s2_hold, s2_v_reg && !en3, s2_v_reg, "stage 2 item dropped on stall")
    `BBW_ASSERT_IMPLIES(a_ready_bubble, !out_v_reg || mean_ready, pixel_ready, "input stalled")

endmodule

/* sv/bbw_ram.sv */
// Generic single write port, single read port RAM with registered read data.
module bbw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* tb/testbench.sv */
// Self-checking testbench for the box blur window filter: scoreboard class plus stream drivers.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    // Quiet cycles (no transfer on any channel) tolerated before the run is declared hung.
    localparam int STALL_LIMIT  = 2000;
    // Cycles to hold after the last mean arrives, as margin.
    localparam int SETTLE       = 8;
    // Random pixels to send after the directed part.
    localparam int RANDOM_ITEMS = 500;

    typedef struct packed {
        logic [bbw_pkg::PIX_W-1:0] red;
        logic [bbw_pkg::PIX_W-1:0] green;
        logic [bbw_pkg::PIX_W-1:0] blue;
    } rgb_t;

    // Tracks the filter state, predicts one mean per accepted pixel and checks the results.
    class mean_tracker;
        bit [bbw_pkg::WIDTH_W-1:0]           width_reg;
        bit [bbw_pkg::NCH*bbw_pkg::PIX_W-1:0] line_mem [bbw_pkg::LINE_DEPTH];
        bit [bbw_pkg::COLSUM_W-1:0]          col_sum [bbw_pkg::MAX_WIDTH][bbw_pkg::NCH];
        bit [bbw_pkg::COLSUM_W-1:0]          ring_sum [bbw_pkg::WINDOW][bbw_pkg::NCH];
        bit [bbw_pkg::WIN_W-1:0]             win_sum [bbw_pkg::NCH];
        int unsigned                         col_pos;
        int unsigned                         rows_seen;
        int unsigned                         slot;
        rgb_t                                expected_means [$];
        int                                  errors;

        function new();
            width_reg = bbw_pkg::WIDTH_W'(bbw_pkg::MAX_WIDTH);
            col_pos   = 0;
            rows_seen = 0;
            slot      = 0;
            errors    = 0;
            foreach (ring_sum[i, c])
                ring_sum[i][c] = '0;
            foreach (win_sum[c])
                win_sum[c] = '0;
        endfunction

        function void set_width(bit [bbw_pkg::WIDTH_W-1:0] v);
            width_reg = v;
        endfunction

        // Zero acts as one pixel, anything past the line store acts as its full width.
        function int unsigned active_width();
            if (width_reg == 0)
                return 1;
            if (width_reg > bbw_pkg::MAX_WIDTH)
                return bbw_pkg::MAX_WIDTH;
            return width_reg;
        endfunction

        function int pending();
            return expected_means.size();
        endfunction

        function void next_line();
            col_pos = 0;
            slot = (slot + 1) % bbw_pkg::WINDOW;
            if (rows_seen < bbw_pkg::WINDOW)
                rows_seen++;
        endfunction

        function void flag(string msg);
            errors++;
            if (errors <= 10)
                $display("%s", msg);
        endfunction

        function void note_pixel(rgb_t p, bit fs);
            bit [bbw_pkg::PIX_W-1:0]              px [bbw_pkg::NCH];
            bit [bbw_pkg::PIX_W-1:0]              mv [bbw_pkg::NCH];
            bit [bbw_pkg::NCH*bbw_pkg::PIX_W-1:0] old;
            bit [bbw_pkg::COLSUM_W-1:0]           cs;
            int unsigned                          w;
            int unsigned                          col;
            int unsigned                          ring;
            int unsigned                          idx;
            px[0] = p.red;
            px[1] = p.green;
            px[2] = p.blue;
            if (fs) begin
                col_pos   = 0;
                rows_seen = 0;
                slot      = 0;
            end
            w = active_width();
            if (col_pos >= w)
                next_line();
            if (col_pos == 0) begin
                foreach (ring_sum[i, c])
                    ring_sum[i][c] = '0;
                foreach (win_sum[c])
                    win_sum[c] = '0;
            end
            col  = col_pos;
            idx  = slot * bbw_pkg::MAX_WIDTH + col;
            old  = line_mem[idx];
            ring = col % bbw_pkg::WINDOW;
            for (int c = 0; c < bbw_pkg::NCH; c++) begin
                if (rows_seen == 0) begin
                    cs = bbw_pkg::COLSUM_W'(px[c]);
                end
                else begin
                    cs = col_sum[col][c] + bbw_pkg::COLSUM_W'(px[c]);
                    if (rows_seen >= bbw_pkg::WINDOW)
                        cs = cs - bbw_pkg::COLSUM_W'(
                                 old[bbw_pkg::PIX_W*(bbw_pkg::NCH-1-c) +: bbw_pkg::PIX_W]);
                end
                col_sum[col][c]   = cs;
                win_sum[c]        = win_sum[c] + bbw_pkg::WIN_W'(cs)
                                  - bbw_pkg::WIN_W'(ring_sum[ring][c]);
                ring_sum[ring][c] = cs;
                mv[c] = bbw_pkg::PIX_W'(win_sum[c] / bbw_pkg::AREA);
            end
            line_mem[idx] = {px[0], px[1], px[2]};
            col_pos = col + 1;
            if (col_pos >= w)
                next_line();
            expected_means.push_back(rgb_t'{mv[0], mv[1], mv[2]});
        endfunction

        function void check_mean(rgb_t got);
            rgb_t want;
            if (expected_means.size() == 0) begin
                flag($sformatf("unexpected mean r=%0d g=%0d b=%0d",
                               got.red, got.green, got.blue));
                return;
            end
            want = expected_means.pop_front();
            if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue)
                flag($sformatf("mean mismatch: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                               want.red, want.green, want.blue,
                               got.red, got.green, got.blue));
        endfunction

        function void close();
            if (expected_means.size() != 0)
                flag($sformatf("%0d means never arrived", expected_means.size()));
        endfunction
    endclass

    logic                          clk;
    logic                          rst_n;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [bbw_pkg::WIDTH_W-1:0]   row_width;
    logic                          pixel_valid;
    logic                          pixel_ready;
    logic [bbw_pkg::PIX_W-1:0]     pixel_red;
    logic [bbw_pkg::PIX_W-1:0]     pixel_green;
    logic [bbw_pkg::PIX_W-1:0]     pixel_blue;
    logic                          frame_start;
    logic                          mean_valid;
    logic                          mean_ready;
    logic [bbw_pkg::PIX_W-1:0]     mean_red;
    logic [bbw_pkg::PIX_W-1:0]     mean_green;
    logic [bbw_pkg::PIX_W-1:0]     mean_blue;

    mean_tracker sb = new();

    // Sender pacing: pixels left in the current burst, and whether gaps fall between bursts.
    int          burst_left;
    bit          gappy;
    // Narrowest width used since the frame began; a wider row would read unwritten store entries.
    int unsigned frame_cap;
    // Set when the next pixel must open a new frame.
    bit          force_fs;
    int          random_count;

    box_blur_window_filter uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .row_width   (row_width),
        .pixel_valid (pixel_valid),
        .pixel_ready (pixel_ready),
        .pixel_red   (pixel_red),
        .pixel_green (pixel_green),
        .pixel_blue  (pixel_blue),
        .frame_start (frame_start),
        .mean_valid  (mean_valid),
        .mean_ready  (mean_ready),
        .mean_red    (mean_red),
        .mean_green  (mean_green),
        .mean_blue   (mean_blue)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Present one pixel at the falling edge and hold it until the transfer; then log it.
    // Valid stays high on return so back-to-back pixels never drop it between them.
    task automatic push_pixel(rgb_t p, bit fs);
        bit eff_fs;
        eff_fs   = fs | force_fs;
        force_fs = 1'b0;
        @(negedge clk);
        pixel_valid <= 1'b1;
        pixel_red   <= p.red;
        pixel_green <= p.green;
        pixel_blue  <= p.blue;
        frame_start <= eff_fs;
        do
            @(posedge clk);
        while (!pixel_ready);
        sb.note_pixel(p, eff_fs);
        if (eff_fs)
            frame_cap = sb.active_width();
    endtask

    task automatic idle_sender(int n);
        repeat (n)
        begin
            @(negedge clk);
            pixel_valid <= 1'b0;
        end
    endtask

    // Send in bursts of random length; between bursts, when gappy is set, drop valid for a random gap.
    task automatic stream_pixel(rgb_t p, bit fs);
        if (burst_left == 0) begin
            if (gappy)
                idle_sender($urandom_range(0, 20));
            burst_left = $urandom_range(1, 64);
        end
        burst_left--;
        push_pixel(p, fs);
    endtask

    // Drop valid, wait for every predicted mean, then hold while the pipeline empties.
    task automatic drain();
        @(negedge clk);
        pixel_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Write row_width. Keep the current frame only if the new width is not wider than every
    // row of it so far; otherwise force a frame start on the next pixel.
    task automatic write_width(bit [bbw_pkg::WIDTH_W-1:0] v, bit keep_frame);
        int unsigned act;
        @(negedge clk);
        cfg_valid <= 1'b1;
        row_width <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.set_width(v);
        @(negedge clk);
        cfg_valid <= 1'b0;
        act = sb.active_width();
        if (keep_frame && act <= frame_cap) begin
            force_fs  = 1'b0;
            frame_cap = act;
        end
        else begin
            force_fs = 1'b1;
        end
    endtask

    // Pick one channel level in the flavor of the current phase.
    function automatic logic [bbw_pkg::PIX_W-1:0] pick_level(int style);
        case (style)
            1:       return ($urandom_range(0, 7) == 0) ?
                            bbw_pkg::PIX_W'($urandom_range(0, 255)) : 8'd255;
            2:       return $urandom_range(0, 1) ? 8'd255 : 8'd0;
            3:       return bbw_pkg::PIX_W'($urandom_range(0, 15));
            default: return bbw_pkg::PIX_W'($urandom_range(0, 255));
        endcase
    endfunction

    // Count quiet cycles; end the run if nothing moves for too long.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge clk);
            if ((pixel_valid && pixel_ready) || (mean_valid && mean_ready)
                || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("== FAIL ==");
        $finish;
    end

    // Receiver: stall on a pattern that changes from span to span.
    initial
    begin : mean_sink
        int mode;
        int span;
        int period;
        int on_len;
        int tick;
        mean_ready = 1'b0;
        tick = 0;
        forever begin
            mode   = $urandom_range(0, 3);
            span   = $urandom_range(50, 300);
            period = $urandom_range(2, 12);
            on_len = $urandom_range(1, period - 1);
            repeat (span)
            begin
                @(negedge clk);
                case (mode)
                    0:       mean_ready <= 1'b1;
                    1:       mean_ready <= 1'($urandom_range(0, 1));
                    2:       mean_ready <= (tick % period) < on_len;
                    default: mean_ready <= ($urandom_range(0, 3) == 0);
                endcase
                tick++;
            end
        end
    end

    // Check every mean transfer against the oldest prediction.
    initial
    begin : mean_monitor
        forever begin
            @(posedge clk);
            if (rst_n === 1'b1 && mean_valid === 1'b1 && mean_ready === 1'b1)
                sb.check_mean(rgb_t'{mean_red, mean_green, mean_blue});
        end
    end

    initial
    begin : main
        int                        pick;
        int                        style;
        int                        phase_len;
        int                        fs_odds;
        int unsigned               act;
        bit [bbw_pkg::WIDTH_W-1:0] wval;
        bit                        noisy;
        bit                        fs;

        rst_n        = 1'b0;
        cfg_valid    = 1'b0;
        row_width    = bbw_pkg::WIDTH_W'(bbw_pkg::MAX_WIDTH);
        pixel_valid  = 1'b0;
        pixel_red    = '0;
        pixel_green  = '0;
        pixel_blue   = '0;
        frame_start  = 1'b0;
        burst_left   = 0;
        gappy        = 1'b0;
        frame_cap    = bbw_pkg::MAX_WIDTH;
        force_fs     = 1'b0;
        random_count = 0;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed: reset width, no frame start, so the stream runs as an implicit frame.
        push_pixel(rgb_t'{8'd255, 8'd255, 8'd255}, 1'b0);
        push_pixel(rgb_t'{8'd0, 8'd0, 8'd0}, 1'b0);
        push_pixel(rgb_t'{8'd255, 8'd0, 8'd128}, 1'b0);
        push_pixel(rgb_t'{8'd1, 8'd2, 8'd4}, 1'b0);
        push_pixel(rgb_t'{8'd0, 8'd255, 8'd0}, 1'b0);
        push_pixel(rgb_t'{8'd170, 8'd85, 8'd255}, 1'b0);
        drain();

        // Width zero acts as one pixel; shrinking mid-row wraps to a new row at once.
        // Fourteen bright rows fill the window and start dropping the oldest row.
        write_width('0, 1'b1);
        for (int i = 0; i < 14; i++)
            push_pixel(rgb_t'{8'd255, 8'd255, 8'd255}, 1'b0);
        drain();

        // Width above the line store acts as full width; widening forces a new frame,
        // and a second frame start lands mid-row.
        write_width('1, 1'b1);
        push_pixel(rgb_t'{8'd255, 8'd255, 8'd255}, 1'b1);
        push_pixel(rgb_t'{8'd0, 8'd0, 8'd0}, 1'b0);
        push_pixel(rgb_t'{8'd128, 8'd64, 8'd32}, 1'b0);
        push_pixel(rgb_t'{8'd255, 8'd0, 8'd255}, 1'b1);
        drain();

        // One long phase at full width so rows wrap at the largest size.
        write_width(bbw_pkg::WIDTH_W'(bbw_pkg::MAX_WIDTH), 1'b1);
        gappy = 1'b1;
        burst_left = 0;
        style = $urandom_range(0, 3);
        for (int i = 0; i < bbw_pkg::MAX_WIDTH + 16; i++)
            stream_pixel(rgb_t'{pick_level(style), pick_level(style), pick_level(style)},
                         ($urandom_range(0, 999) == 0));
        drain();

        // Random phases: mostly whole frames of small width with random content; a few noisy
        // phases with frequent frame starts, and a few short ones at full width.
        while (random_count < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 9);
            case (pick)
                0:       wval = '0;
                1:       wval = bbw_pkg::WIDTH_W'(1);
                2:       wval = bbw_pkg::WIDTH_W'(bbw_pkg::WINDOW);
                3:       wval = bbw_pkg::WIDTH_W'($urandom_range(bbw_pkg::MAX_WIDTH, 2047));
                4:       wval = bbw_pkg::WIDTH_W'($urandom_range(2, bbw_pkg::WINDOW - 1));
                default: wval = bbw_pkg::WIDTH_W'($urandom_range(1, 24));
            endcase
            write_width(wval, $urandom_range(0, 2) == 0);
            act   = sb.active_width();
            noisy = ($urandom_range(0, 5) == 0);
            if (act >= bbw_pkg::MAX_WIDTH)
                phase_len = $urandom_range(20, 60);
            else if (noisy)
                phase_len = $urandom_range(5, 40);
            else
                phase_len = act * $urandom_range(bbw_pkg::WINDOW, bbw_pkg::WINDOW + 4);
            fs_odds    = noisy ? 3 : 400;
            style      = $urandom_range(0, 3);
            gappy      = ($urandom_range(0, 3) != 0);
            burst_left = 0;
            for (int i = 0; i < phase_len; i++) begin
                fs = ($urandom_range(0, fs_odds) == 0);
                stream_pixel(rgb_t'{pick_level(style), pick_level(style), pick_level(style)}, fs);
                random_count++;
            end
            drain();
        end

        sb.close();
        if (sb.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
